// File: sv/speq_pkg.sv
// Shared types and codes for the strict priority event queue.
// Depends on nothing; imported by every module of the block.
package speq_pkg;

	localparam logic MODE_PUSH = 1'b0;
	localparam logic MODE_POP  = 1'b1;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	typedef struct packed {
		logic        mode;
		logic [3:0]  priority_req;
		logic [63:0] payload;
	} speq_req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [63:0] popped_payload;
		logic [1:0]  popped_level;
		logic [6:0]  total_entries;
	} speq_rsp_t;

	typedef struct packed {
		logic load;
		logic exec;
		logic respond;
	} speq_cmd_t;

endpackage

// File: sv/speq_ctrl.sv
// Controller of the strict priority event queue: sequences load, execute
// and respond steps for each item. Depends on speq_pkg.
module speq_ctrl
	import speq_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	output logic      busy,
	output speq_cmd_t cmd
);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_EXEC = 3'b010,
		S_RESP = 3'b100
	} state_t;

	state_t state_q;
	state_t state_nxt;
	logic   accept;

	assign busy   = (state_q == S_EXEC);
	assign accept = start && !busy;

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) state_nxt = S_EXEC;
			end
			S_EXEC: begin
				state_nxt = S_RESP;
			end
			S_RESP: begin
				state_nxt = accept ? S_EXEC : S_IDLE;
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	assign cmd.load    = accept;
	assign cmd.exec    = (state_q == S_EXEC);
	assign cmd.respond = (state_q == S_RESP);

endmodule

// File: sv/speq_dp.sv
// Datapath of the strict priority event queue: per-level FIFO pointers,
// fill counts, total count and the entry memory. Depends on speq_pkg.
module speq_dp
	import speq_pkg::*;
#(
	parameter int PRIORITY_LEVELS = 4,
	parameter int LEVEL_DEPTH     = 16,
	parameter int PAYLOAD_WIDTH   = 64
) (
	input  logic      clk,
	input  logic      arst_n,
	input  speq_cmd_t cmd,
	input  speq_req_t req,
	output speq_rsp_t rsp
);

	localparam int LW = (PRIORITY_LEVELS > 1) ? $clog2(PRIORITY_LEVELS) : 1;
	localparam int PW = (LEVEL_DEPTH > 1) ? $clog2(LEVEL_DEPTH) : 1;
	localparam int FW = $clog2(LEVEL_DEPTH + 1);
	localparam int SD = PRIORITY_LEVELS * LEVEL_DEPTH;
	localparam int AW = (SD > 1) ? $clog2(SD) : 1;
	localparam int TW = $clog2(SD + 1);

	speq_req_t               req_q;
	logic [PW-1:0]           head_q [PRIORITY_LEVELS];
	logic [PW-1:0]           tail_q [PRIORITY_LEVELS];
	logic [FW-1:0]           fill_q [PRIORITY_LEVELS];
	logic [TW-1:0]           total_q;
	logic [1:0]              status_q;
	logic [LW-1:0]           lvl_q;
	logic                    pop_ok_q;
	logic [PAYLOAD_WIDTH-1:0] rd_q;
	logic [PAYLOAD_WIDTH-1:0] mem [SD];

	logic [LW-1:0]           push_lvl;
	logic [LW-1:0]           pop_lvl;
	logic                    pop_found;
	logic [LW-1:0]           lvl;
	logic                    push_ok;
	logic                    pop_ok;
	logic [PW-1:0]           ptr;
	logic [PW-1:0]           ptr_inc;
	logic [AW-1:0]           addr;

	assign push_lvl = ({1'b0, req_q.priority_req} < 5'(PRIORITY_LEVELS)) ?
		req_q.priority_req[LW-1:0] : '0;

	always_comb begin
		pop_found = 1'b0;
		pop_lvl   = '0;
		for (int i = 0; i < PRIORITY_LEVELS; i++) begin
			if (fill_q[i] != '0) begin
				pop_found = 1'b1;
				pop_lvl   = LW'(i);
			end
		end
	end

	assign lvl     = (req_q.mode == MODE_POP) ? pop_lvl : push_lvl;
	assign push_ok = (req_q.mode == MODE_PUSH) && (fill_q[push_lvl] != FW'(LEVEL_DEPTH));
	assign pop_ok  = (req_q.mode == MODE_POP) && pop_found;
	assign ptr     = (req_q.mode == MODE_POP) ? head_q[lvl] : tail_q[lvl];
	assign ptr_inc = (ptr == PW'(LEVEL_DEPTH - 1)) ? '0 : ptr + PW'(1);
	assign addr    = AW'(int'(lvl) * LEVEL_DEPTH) + AW'(ptr);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= req;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec && push_ok) begin
			mem[addr] <= req_q.payload[PAYLOAD_WIDTH-1:0];
		end
		if (cmd.exec && pop_ok) begin
			rd_q <= mem[addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < PRIORITY_LEVELS; i++) begin
				head_q[i] <= '0;
				tail_q[i] <= '0;
				fill_q[i] <= '0;
			end
			total_q  <= '0;
			status_q <= ST_OK;
			lvl_q    <= '0;
			pop_ok_q <= 1'b0;
		end else if (cmd.exec) begin
			pop_ok_q <= pop_ok;
			lvl_q    <= pop_lvl;
			if (push_ok) begin
				tail_q[lvl] <= ptr_inc;
				fill_q[lvl] <= fill_q[lvl] + FW'(1);
				total_q     <= total_q + TW'(1);
				status_q    <= ST_OK;
			end else if (pop_ok) begin
				head_q[lvl] <= ptr_inc;
				fill_q[lvl] <= fill_q[lvl] - FW'(1);
				total_q     <= total_q - TW'(1);
				status_q    <= ST_OK;
			end else begin
				status_q <= (req_q.mode == MODE_POP) ? ST_EMPTY : ST_FULL;
			end
		end
	end

	assign rsp.status         = status_q;
	assign rsp.popped_payload = pop_ok_q ? 64'(rd_q) : 64'd0;
	assign rsp.popped_level   = pop_ok_q ? 2'(lvl_q) : 2'd0;
	assign rsp.total_entries  = 7'(total_q);

endmodule

// File: sv/strict_priority_event_queue.sv
// Strict priority event queue: one FIFO per priority level, highest first.
// Depends on speq_pkg, speq_ctrl and speq_dp.
//
// Usage:
//   Request channel: drive req and raise start; the item is taken at a
//   rising edge where start is high and busy is low. req.mode selects push
//   or pop; a push priority at or above PRIORITY_LEVELS goes to level 0.
//   Result channel: done is high for exactly one cycle, the respond state
//   after the item's execute state, with rsp valid in that cycle. Every item
//   gives one result: status, popped payload and level, and total entries
//   queued. The receiver cannot stall; a result not taken in its cycle is gone.
// Flow:
//   busy is high in the execute state, in which the level is chosen and
//   the single-port entry memory is written or read; a new item may be
//   taken during the cycle its predecessor's result shows.
// Reset:
//   arst_n clears all pointers, fill counts and the total; the queue is
//   empty afterward. The entry memory is not cleared.
module strict_priority_event_queue
	import speq_pkg::*;
#(
	parameter int PRIORITY_LEVELS = 4,
	parameter int LEVEL_DEPTH     = 16,
	parameter int PAYLOAD_WIDTH   = 64
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	output logic      busy,
	input  speq_req_t req,
	output logic      done,
	output speq_rsp_t rsp
);

	speq_cmd_t cmd;

	speq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd)
	);

	speq_dp #(
		.PRIORITY_LEVELS (PRIORITY_LEVELS),
		.LEVEL_DEPTH     (LEVEL_DEPTH),
		.PAYLOAD_WIDTH   (PAYLOAD_WIDTH)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.req    (req),
		.rsp    (rsp)
	);

	assign done = cmd.respond;

endmodule

// File: test/tb.sv
// Testbench for strict_priority_event_queue: directed table, then random push/pop traffic.
// Results are checked against table values or a behavioral model of the per-level FIFOs.
// Depends on speq_pkg and strict_priority_event_queue.
`timescale 1ns / 1ps

module tb;
	import speq_pkg::*;

	localparam int LEVELS = 4;
	localparam int DEPTH  = 16;
	localparam int BLOCKS = 9;
	localparam int BLOCK_ITEMS = 50;

	typedef struct packed {
		logic        mode;
		logic [3:0]  prio;
		logic [63:0] payload;
		logic        typed;
		logic [1:0]  want_status;
		logic [63:0] want_payload;
		logic [1:0]  want_level;
		logic [6:0]  want_total;
	} plan_row_t;

	logic      clk;
	logic      arst_n;
	logic      start;
	logic      busy;
	speq_req_t req;
	logic      done;
	speq_rsp_t rsp;

	logic [63:0] level_store [LEVELS][DEPTH];
	int          level_head [LEVELS];
	int          level_tail [LEVELS];
	int          level_fill [LEVELS];
	int          queued_total;

	speq_rsp_t expected_rsp_q [$];
	int        mismatch_count;
	int        items_sent;
	int        results_seen;
	int        refused_pushes;
	int        empty_pops;
	int        peak_total;
	bit        idle_on;

	plan_row_t plan [19];
	int        push_pct [BLOCKS];

	strict_priority_event_queue #(
		.PRIORITY_LEVELS(LEVELS),
		.LEVEL_DEPTH(DEPTH),
		.PAYLOAD_WIDTH(64)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req(req),
		.done(done),
		.rsp(rsp)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("[strict_priority_event_queue] ERROR");
		$finish;
	end

	task automatic queue_step(input speq_req_t item, output speq_rsp_t r);
		int  lvl;
		bit  found;
		r = '0;
		r.status = ST_OK;
		if (item.mode == MODE_PUSH) begin
			lvl = (item.priority_req < LEVELS) ? int'(item.priority_req) : 0;
			if (level_fill[lvl] >= DEPTH) begin
				r.status = ST_FULL;
				refused_pushes++;
			end else begin
				level_store[lvl][level_tail[lvl]] = item.payload;
				level_tail[lvl] = (level_tail[lvl] + 1) % DEPTH;
				level_fill[lvl]++;
				queued_total++;
			end
		end else begin
			found = 1'b0;
			for (int i = LEVELS - 1; i >= 0; i--) begin
				if (!found && level_fill[i] != 0) begin
					r.popped_payload = level_store[i][level_head[i]];
					r.popped_level = i[1:0];
					level_head[i] = (level_head[i] + 1) % DEPTH;
					level_fill[i]--;
					queued_total--;
					found = 1'b1;
				end
			end
			if (!found) begin
				r.status = ST_EMPTY;
				empty_pops++;
			end
		end
		if (queued_total > peak_total)
			peak_total = queued_total;
		r.total_entries = queued_total[6:0];
	endtask

	task automatic issue(input speq_req_t item, input bit typed, input speq_rsp_t typed_rsp);
		speq_rsp_t predicted;
		while (idle_on && $urandom_range(99) < 31) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start <= 1'b1;
		req <= item;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		queue_step(item, predicted);
		expected_rsp_q.push_back(typed ? typed_rsp : predicted);
		items_sent++;
		@(negedge clk);
	endtask

	always @(posedge clk) begin
		speq_rsp_t want;
		if (arst_n && done) begin
			results_seen++;
			if (expected_rsp_q.size() == 0) begin
				$error("result with no item outstanding");
				mismatch_count++;
			end else begin
				want = expected_rsp_q.pop_front();
				if (rsp.status !== want.status) begin
					$error("status expected %0d got %0d", want.status, rsp.status);
					mismatch_count++;
				end
				if (rsp.popped_payload !== want.popped_payload) begin
					$error("popped_payload expected %h got %h",
						want.popped_payload, rsp.popped_payload);
					mismatch_count++;
				end
				if (rsp.popped_level !== want.popped_level) begin
					$error("popped_level expected %0d got %0d",
						want.popped_level, rsp.popped_level);
					mismatch_count++;
				end
				if (rsp.total_entries !== want.total_entries) begin
					$error("total_entries expected %0d got %0d",
						want.total_entries, rsp.total_entries);
					mismatch_count++;
				end
			end
		end
	end

	initial begin
		speq_req_t item;
		speq_rsp_t want;
		int        wait_cycles;

		start = 1'b0;
		req = '0;
		arst_n = 1'b0;
		idle_on = 1'b1;
		mismatch_count = 0;
		items_sent = 0;
		results_seen = 0;
		refused_pushes = 0;
		empty_pops = 0;
		peak_total = 0;
		queued_total = 0;
		for (int l = 0; l < LEVELS; l++) begin
			level_head[l] = 0;
			level_tail[l] = 0;
			level_fill[l] = 0;
		end

		plan = '{
			'{MODE_POP,  4'd0,  64'd0,                  1'b1, ST_EMPTY, 64'd0, 2'd0, 7'd0},
			'{MODE_PUSH, 4'd3,  64'hFFFF_FFFF_FFFF_FFFF, 1'b1, ST_OK, 64'd0, 2'd0, 7'd1},
			'{MODE_PUSH, 4'd15, 64'd0,                  1'b1, ST_OK, 64'd0, 2'd0, 7'd2},
			'{MODE_PUSH, 4'd4,  64'h8000_0000_0000_0001, 1'b1, ST_OK, 64'd0, 2'd0, 7'd3},
			'{MODE_PUSH, 4'd1,  64'h5555_5555_5555_5555, 1'b1, ST_OK, 64'd0, 2'd0, 7'd4},
			'{MODE_PUSH, 4'd2,  64'hAAAA_AAAA_AAAA_AAAA, 1'b1, ST_OK, 64'd0, 2'd0, 7'd5},
			'{MODE_POP,  4'd15, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, ST_OK,
				64'hFFFF_FFFF_FFFF_FFFF, 2'd3, 7'd4},
			'{MODE_POP,  4'd0,  64'd0, 1'b1, ST_OK, 64'hAAAA_AAAA_AAAA_AAAA, 2'd2, 7'd3},
			'{MODE_POP,  4'd0,  64'd0, 1'b1, ST_OK, 64'h5555_5555_5555_5555, 2'd1, 7'd2},
			'{MODE_POP,  4'd0,  64'd0, 1'b1, ST_OK, 64'd0, 2'd0, 7'd1},
			'{MODE_POP,  4'd0,  64'd0, 1'b1, ST_OK, 64'h8000_0000_0000_0001, 2'd0, 7'd0},
			'{MODE_POP,  4'd0,  64'd0, 1'b1, ST_EMPTY, 64'd0, 2'd0, 7'd0},
			'{MODE_PUSH, 4'd0,  64'h0123_4567_89AB_CDEF, 1'b0, ST_OK, 64'd0, 2'd0, 7'd0},
			'{MODE_PUSH, 4'd3,  64'hFEDC_BA98_7654_3210, 1'b0, ST_OK, 64'd0, 2'd0, 7'd0},
			'{MODE_PUSH, 4'd7,  64'h0F0F_F0F0_3C3C_C3C3, 1'b0, ST_OK, 64'd0, 2'd0, 7'd0},
			'{MODE_POP,  4'd8,  64'h1234_0000_0000_5678, 1'b0, ST_OK, 64'd0, 2'd0, 7'd0},
			'{MODE_POP,  4'd0,  64'd0, 1'b0, ST_OK, 64'd0, 2'd0, 7'd0},
			'{MODE_POP,  4'd0,  64'd0, 1'b0, ST_OK, 64'd0, 2'd0, 7'd0},
			'{MODE_POP,  4'd0,  64'd0, 1'b1, ST_EMPTY, 64'd0, 2'd0, 7'd0}
		};
		push_pct = '{95, 10, 55, 95, 55, 10, 100, 5, 55};

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (plan[i]) begin
			item.mode = plan[i].mode;
			item.priority_req = plan[i].prio;
			item.payload = plan[i].payload;
			want.status = plan[i].want_status;
			want.popped_payload = plan[i].want_payload;
			want.popped_level = plan[i].want_level;
			want.total_entries = plan[i].want_total;
			issue(item, plan[i].typed, want);
		end

		// hold off until the queue of outstanding results drains
		start <= 1'b0;
		while (expected_rsp_q.size() != 0)
			@(posedge clk);
		@(negedge clk);

		for (int b = 0; b < BLOCKS; b++) begin
			idle_on = !(b == 3 || b == 4);
			if (b == 5) begin
				start <= 1'b0;
				while (expected_rsp_q.size() != 0)
					@(posedge clk);
				@(negedge clk);
			end
			for (int n = 0; n < BLOCK_ITEMS; n++) begin
				item.mode = ($urandom_range(99) < push_pct[b]) ? MODE_PUSH : MODE_POP;
				if (b == 6 || $urandom_range(1) == 0)
					item.priority_req = 4'($urandom_range(LEVELS - 1));
				else
					item.priority_req = 4'($urandom_range(15));
				item.payload = {$urandom, $urandom};
				issue(item, 1'b0, '0);
			end
		end
		start <= 1'b0;

		wait_cycles = 0;
		while (expected_rsp_q.size() != 0 && wait_cycles < 1000) begin
			@(posedge clk);
			wait_cycles++;
		end
		repeat (5) @(posedge clk);
		if (expected_rsp_q.size() != 0) begin
			$error("%0d results never arrived", expected_rsp_q.size());
			mismatch_count++;
		end

		$display("Sent %0d items, checked %0d results, %0d mismatches.",
			items_sent, results_seen, mismatch_count);
		$display("Refused pushes on full levels: %0d, pops of empty queue: %0d, peak depth: %0d.",
			refused_pushes, empty_pops, peak_total);
		if (mismatch_count == 0)
			$display("[strict_priority_event_queue] OK");
		else
			$display("[strict_priority_event_queue] ERROR");
		$finish;
	end

endmodule

// File: filelist.f
sv/speq_pkg.sv
sv/speq_ctrl.sv
sv/speq_dp.sv
sv/strict_priority_event_queue.sv
test/tb.sv
